@@ rtl/asfs_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asfs_pkg
// Beat types, operation codes and flag positions for the status flag and
// shifter unit.
// ----------------------------------------------------------------------------
package asfs_pkg;

    // Operation codes carried in the kind field
    localparam logic [3:0] KIND_COND  = 4'd0;
    localparam logic [3:0] KIND_LSL   = 4'd1;
    localparam logic [3:0] KIND_LSR   = 4'd2;
    localparam logic [3:0] KIND_ASR   = 4'd3;
    localparam logic [3:0] KIND_ROR   = 4'd4;
    localparam logic [3:0] KIND_NZ    = 4'd5;
    localparam logic [3:0] KIND_NZC   = 4'd6;
    localparam logic [3:0] KIND_ADD   = 4'd7;
    localparam logic [3:0] KIND_ADC   = 4'd8;
    localparam logic [3:0] KIND_SUB   = 4'd9;
    localparam logic [3:0] KIND_SBC   = 4'd10;
    localparam logic [3:0] KIND_WRITE = 4'd11;
    localparam logic [3:0] KIND_READ  = 4'd12;

    // ARM condition field
    localparam logic [3:0] COND_EQ = 4'h0;
    localparam logic [3:0] COND_NE = 4'h1;
    localparam logic [3:0] COND_CS = 4'h2;
    localparam logic [3:0] COND_CC = 4'h3;
    localparam logic [3:0] COND_MI = 4'h4;
    localparam logic [3:0] COND_PL = 4'h5;
    localparam logic [3:0] COND_VS = 4'h6;
    localparam logic [3:0] COND_VC = 4'h7;
    localparam logic [3:0] COND_HI = 4'h8;
    localparam logic [3:0] COND_LS = 4'h9;
    localparam logic [3:0] COND_GE = 4'hA;
    localparam logic [3:0] COND_LT = 4'hB;
    localparam logic [3:0] COND_GT = 4'hC;
    localparam logic [3:0] COND_LE = 4'hD;
    localparam logic [3:0] COND_AL = 4'hE;

    // Flag bit positions in the status word
    localparam int FLAG_N_BIT = 31;
    localparam int FLAG_Z_BIT = 30;
    localparam int FLAG_C_BIT = 29;
    localparam int FLAG_V_BIT = 28;

    typedef struct packed {
        logic [3:0]  kind;
        logic [31:0] operand_a;
        logic [31:0] operand_b;
        logic [31:0] result_value;
        logic [7:0]  shift_amount;
        logic        carry_in;
        logic        update_carry;
        logic [3:0]  cond_code;
        logic [3:0]  field_mask;
    } in_beat_t;

    typedef struct packed {
        logic [31:0] data_out;
        logic        cond_pass;
        logic [31:0] status_out;
    } out_beat_t;

endpackage

@@ rtl/arm_status_flag_and_shifter_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arm_status_flag_and_shifter_unit
// ARMv4T status word with condition test, barrel shifter and flag updates.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_ready carry one operation beat (in_data); out_valid/out_ready
//   carry one result beat (out_data) for every operation beat.
//   A beat lands in the input register, is evaluated in one pass of
//   combinational logic against the held status word, and moves into the
//   output register; the status word updates on that same edge.
//   out_valid rises once the beat moves into the output register. Throughput
//   is one beat per cycle while the receiver does not stall; the next operation
//   always sees the status left by the previous one.
//   When the receiver stalls, the output register holds its beat and the
//   input register keeps one more; in_ready then drops until out_ready
//   returns.
//   Reset clears both valid flags and the status word to zero.
// ----------------------------------------------------------------------------
module arm_status_flag_and_shifter_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  asfs_pkg::in_beat_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output asfs_pkg::out_beat_t out_data
);
    import asfs_pkg::*;

    logic        in_valid_reg;
    in_beat_t    in_beat_reg;
    logic        out_valid_reg;
    out_beat_t   out_beat_reg;
    logic [31:0] status_reg;
    logic [31:0] status_next;

    logic        advance;
    logic        flag_n;
    logic        flag_z;
    logic        flag_c;
    logic        flag_v;
    logic        pass;
    logic [31:0] data;

    logic [4:0]  amt_lo;
    logic        amt_big;
    logic        amt_32;
    logic [32:0] lsl_wide;
    logic [32:0] lsr_wide;
    logic [32:0] asr_wide;
    logic [63:0] ror_wide;
    logic [31:0] shift_val;
    logic        shift_cy;

    logic [31:0] b_eff;
    logic        c_eff;
    logic [32:0] sum;
    logic        ovf;
    logic [31:0] byte_mask;
    logic [31:0] nz_status;

    // Handshake: input stage moves forward when output register is free
    assign advance   = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !in_valid_reg || advance;
    assign out_valid = out_valid_reg;
    assign out_data  = out_beat_reg;

    assign flag_n = status_reg[FLAG_N_BIT];
    assign flag_z = status_reg[FLAG_Z_BIT];
    assign flag_c = status_reg[FLAG_C_BIT];
    assign flag_v = status_reg[FLAG_V_BIT];

    // Condition evaluation against flags before this beat
    always_comb
    begin
        case (in_beat_reg.cond_code)
            COND_EQ: pass = flag_z;
            COND_NE: pass = !flag_z;
            COND_CS: pass = flag_c;
            COND_CC: pass = !flag_c;
            COND_MI: pass = flag_n;
            COND_PL: pass = !flag_n;
            COND_VS: pass = flag_v;
            COND_VC: pass = !flag_v;
            COND_HI: pass = flag_c && !flag_z;
            COND_LS: pass = !flag_c || flag_z;
            COND_GE: pass = (flag_n == flag_v);
            COND_LT: pass = (flag_n != flag_v);
            COND_GT: pass = !flag_z && (flag_n == flag_v);
            COND_LE: pass = flag_z || (flag_n != flag_v);
            COND_AL: pass = 1'b1;
            default: pass = 1'b0;
        endcase
    end

    // Barrel shifter; the extra bit of the LSL, LSR and ASR vectors captures carry-out
    assign amt_lo  = in_beat_reg.shift_amount[4:0];
    assign amt_big = |in_beat_reg.shift_amount[7:5];
    assign amt_32  = (in_beat_reg.shift_amount == 8'd32);

    assign lsl_wide = {1'b0, in_beat_reg.operand_a} << amt_lo;
    assign lsr_wide = {in_beat_reg.operand_a, 1'b0} >> amt_lo;
    assign asr_wide = 33'($signed({in_beat_reg.operand_a, 1'b0}) >>> amt_lo);
    assign ror_wide = {in_beat_reg.operand_a, in_beat_reg.operand_a} >> amt_lo;

    always_comb
    begin
        shift_val = in_beat_reg.operand_a;
        shift_cy  = 1'b0;
        case (in_beat_reg.kind)
            KIND_LSL:
            begin
                if (amt_big)
                begin
                    shift_val = 32'd0;
                    shift_cy  = amt_32 && in_beat_reg.operand_a[0];
                end
                else
                begin
                    shift_val = lsl_wide[31:0];
                    shift_cy  = lsl_wide[32];
                end
            end
            KIND_LSR:
            begin
                if (amt_big)
                begin
                    shift_val = 32'd0;
                    shift_cy  = amt_32 && in_beat_reg.operand_a[31];
                end
                else
                begin
                    shift_val = lsr_wide[32:1];
                    shift_cy  = lsr_wide[0];
                end
            end
            KIND_ASR:
            begin
                if (amt_big)
                begin
                    shift_val = {32{in_beat_reg.operand_a[31]}};
                    shift_cy  = in_beat_reg.operand_a[31];
                end
                else
                begin
                    shift_val = asr_wide[32:1];
                    shift_cy  = asr_wide[0];
                end
            end
            KIND_ROR:
            begin
                shift_val = ror_wide[31:0];
                shift_cy  = ror_wide[31];
            end
            default:
            begin
                shift_val = in_beat_reg.operand_a;
                shift_cy  = 1'b0;
            end
        endcase
    end

    // Adder carry and overflow; subtract forms invert operand_b
    assign b_eff = (in_beat_reg.kind == KIND_SUB || in_beat_reg.kind == KIND_SBC)
                   ? ~in_beat_reg.operand_b : in_beat_reg.operand_b;
    assign c_eff = (in_beat_reg.kind == KIND_ADC || in_beat_reg.kind == KIND_SBC)
                   ? in_beat_reg.carry_in : (in_beat_reg.kind == KIND_SUB);
    assign sum   = {1'b0, in_beat_reg.operand_a} + {1'b0, b_eff} + {32'd0, c_eff};

    always_comb
    begin
        if (in_beat_reg.kind == KIND_SUB || in_beat_reg.kind == KIND_SBC)
            ovf = (in_beat_reg.operand_a[31] ^ in_beat_reg.operand_b[31])
                  & (in_beat_reg.operand_a[31] ^ in_beat_reg.result_value[31]);
        else
            ovf = ~(in_beat_reg.operand_a[31] ^ in_beat_reg.operand_b[31])
                  & (in_beat_reg.operand_a[31] ^ in_beat_reg.result_value[31]);
    end

    // N and Z from the given result
    always_comb
    begin
        nz_status             = status_reg;
        nz_status[FLAG_N_BIT] = in_beat_reg.result_value[31];
        nz_status[FLAG_Z_BIT] = (in_beat_reg.result_value == 32'd0);
    end

    assign byte_mask = {{8{in_beat_reg.field_mask[3]}}, {8{in_beat_reg.field_mask[2]}},
                        {8{in_beat_reg.field_mask[1]}}, {8{in_beat_reg.field_mask[0]}}};

    // Next status word and data result
    always_comb
    begin
        status_next = status_reg;
        data        = 32'd0;
        case (in_beat_reg.kind)
            KIND_LSL, KIND_LSR, KIND_ASR, KIND_ROR:
            begin
                if (in_beat_reg.shift_amount == 8'd0)
                    data = in_beat_reg.operand_a;
                else
                begin
                    data = shift_val;
                    if (in_beat_reg.update_carry)
                        status_next[FLAG_C_BIT] = shift_cy;
                end
            end
            KIND_NZ:
                status_next = nz_status;
            KIND_NZC:
            begin
                status_next             = nz_status;
                status_next[FLAG_C_BIT] = in_beat_reg.carry_in;
            end
            KIND_ADD, KIND_ADC, KIND_SUB, KIND_SBC:
            begin
                status_next             = nz_status;
                status_next[FLAG_C_BIT] = sum[32];
                status_next[FLAG_V_BIT] = ovf;
            end
            KIND_WRITE:
                status_next = (status_reg & ~byte_mask) | (in_beat_reg.operand_a & byte_mask);
            KIND_READ:
                data = status_reg;
            default:
            begin
                status_next = status_reg;
                data        = 32'd0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            status_reg    <= 32'd0;
        end
        else
        begin
            if (in_ready)
                in_valid_reg <= in_valid;
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                status_reg    <= status_next;
            end
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            in_beat_reg <= in_data;
        if (advance)
        begin
            out_beat_reg.data_out   <= data;
            out_beat_reg.cond_pass  <= pass;
            out_beat_reg.status_out <= status_next;
        end
    end

endmodule
